>>> src/aac_pkg.sv
// Package for the alarm arming controller: modes, LED codes, register map, reset values.
`default_nettype none
package aac_pkg;

   typedef enum logic [1:0] {
      MODE_DISARMED  = 2'd0,
      MODE_COUNTDOWN = 2'd1,
      MODE_ARMED     = 2'd2,
      MODE_INTRUDER  = 2'd3
   } mode_type;

   localparam int DELAY_W = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   // Register indexes, selected by paddr[2]
   localparam logic REG_MIN_DELAY = 1'b0;
   localparam logic REG_MAX_DELAY = 1'b1;

   localparam logic [DELAY_W-1:0] MIN_DELAY_RST = 7'd7;
   localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 7'd99;

   // LED one-hot codes: bit 0 green, bit 1 yellow, bit 2 red
   localparam logic [2:0] LED_OFF    = 3'b000;
   localparam logic [2:0] LED_GREEN  = 3'b001;
   localparam logic [2:0] LED_YELLOW = 3'b010;
   localparam logic [2:0] LED_RED    = 3'b100;

   localparam logic [DELAY_W-1:0] GREEN_FLOOR  = 7'd8;
   localparam logic [DELAY_W-1:0] YELLOW_FLOOR = 7'd5;

   typedef struct packed {
      logic [DELAY_W-1:0] min_delay;
      logic [DELAY_W-1:0] max_delay;
   } cfg_type;

   function automatic logic [2:0] leds_for(input logic [DELAY_W-1:0] shown);
      logic [2:0] led;
      if (shown >= GREEN_FLOOR) begin
         led = LED_GREEN;
      end else if (shown >= YELLOW_FLOOR) begin
         led = LED_YELLOW;
      end else begin
         led = LED_RED;
      end
      return led;
   endfunction

endpackage
`default_nettype wire

>>> src/aac_csr.sv
// Configuration register block: delay limits behind an APB-style port.
`default_nettype none
module aac_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [aac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [aac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [aac_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready,
   output aac_pkg::cfg_type                    cfg
);
   import aac_pkg::*;

   logic [DELAY_W-1:0] min_delay_ff;
   logic [DELAY_W-1:0] max_delay_ff;
   logic               wr_en;
   logic               reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_delay_ff <= MIN_DELAY_RST;
         max_delay_ff <= MAX_DELAY_RST;
      end else if (wr_en) begin
         if (reg_sel == REG_MIN_DELAY) begin
            min_delay_ff <= csr_pwdata[DELAY_W-1:0];
         end else begin
            max_delay_ff <= csr_pwdata[DELAY_W-1:0];
         end
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel == REG_MIN_DELAY) begin
         csr_prdata[DELAY_W-1:0] = min_delay_ff;
      end else begin
         csr_prdata[DELAY_W-1:0] = max_delay_ff;
      end
   end

   assign cfg.min_delay = min_delay_ff;
   assign cfg.max_delay = max_delay_ff;

endmodule
`default_nettype wire

>>> src/alarm_arming_controller.sv
// Alarm arming controller top level: poll stream in, status stream out.
//
// Each beat on the req_ channel is one poll of the arm switch, the one-second
// tick, an encoder step and a beam-break event. Each poll yields exactly one
// status beat on the rsp_ channel: mode, shown count, LED states, laser
// enable and alarm.
// The status of an accepted poll is registered and is valid in the cycle
// after it is accepted. Throughput: one poll per cycle while the receiver
// takes each status beat; the mode update is a single pass of logic from the
// accepted beat and the state registers into the state and the status register.
// When the receiver stalls, the status register holds its beat and req_tready
// stays high only if that beat is taken in the same cycle.
// Reset (synchronous, active high) clears the status valid flag, puts the mode
// to disarmed with delay setting 7, clears all latched events and LEDs, and
// reloads the delay limits to 7 and 99. The csr_ port sets the limits
// (min at byte 0, max at byte 4); writes do not re-clamp the current setting.
`default_nettype none
module alarm_arming_controller (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // tdata: [0] arm_switch, [1] second_tick, [2] encoder_event,
   //        [3] encoder_down, [4] beam_break, [7:5] zero
   input  wire logic [aac_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // tdata: [1:0] mode_now, [8:2] display_count, [9] green_on, [10] yellow_on,
   //        [11] red_on, [12] laser_on, [13] alarm_on, [15:14] zero
   output logic      [aac_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [aac_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [aac_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [aac_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                csr_pready
);
   import aac_pkg::*;

   cfg_type cfg;

   aac_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mode_type           mode_ff, mode_in, mode_eff;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [DELAY_W-1:0] remaining_ff, remaining_in;
   logic               from_armed_ff, from_armed_in;
   logic               beam_latched_ff, beam_latched_in;
   logic               step_pending_ff, step_pending_in;
   logic               step_down_ff, step_down_in;
   logic [2:0]         led_ff, led_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;
   logic               rsp_tvalid_ff;

   logic               arm, tick, enc, down, beam, accept;
   logic signed [8:0]  stepped;
   logic [DELAY_W-1:0] shown;

   assign arm  = req_tdata[0];
   assign tick = req_tdata[1];
   assign enc  = req_tdata[2];
   assign down = req_tdata[3];
   assign beam = req_tdata[4];

   // Take a new poll whenever the status slot is empty or drains this cycle
   assign req_tready = ~rsp_tvalid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      step_pending_in = step_pending_ff | enc;
      step_down_in    = enc ? down : step_down_ff;
      beam_latched_in = beam_latched_ff | beam;
      from_armed_in   = from_armed_ff;
      led_in          = led_ff;
      delay_in        = delay_ff;
      remaining_in    = remaining_ff;
      mode_eff        = arm ? mode_ff : MODE_DISARMED;
      mode_in         = mode_eff;

      // Step by one, clamp to max first, then raise to min
      stepped = signed'({2'b00, delay_ff}) + (step_down_in ? 9'sh1FF : 9'sh001);
      if (stepped > signed'({2'b00, cfg.max_delay})) begin
         stepped = signed'({2'b00, cfg.max_delay});
      end
      if (stepped < signed'({2'b00, cfg.min_delay})) begin
         stepped = signed'({2'b00, cfg.min_delay});
      end

      case (mode_eff)
         MODE_DISARMED: begin
            beam_latched_in = 1'b0;
            from_armed_in   = 1'b0;
            led_in          = LED_OFF;
            if (arm) begin
               mode_in      = MODE_COUNTDOWN;
               remaining_in = delay_ff;
            end else if (step_pending_in) begin
               delay_in        = stepped[DELAY_W-1:0];
               step_pending_in = 1'b0;
            end
         end
         MODE_COUNTDOWN: begin
            if (tick) begin
               led_in = leds_for(remaining_ff);
               if (remaining_ff == '0) begin
                  mode_in = from_armed_ff ? MODE_INTRUDER : MODE_ARMED;
               end else begin
                  remaining_in = remaining_ff - 7'd1;
               end
            end
         end
         MODE_ARMED: begin
            from_armed_in = 1'b1;
            led_in        = LED_OFF;
            if (beam_latched_in) begin
               mode_in      = MODE_COUNTDOWN;
               remaining_in = delay_ff;
            end
         end
         default: begin
            // intruder holds until the switch goes low
         end
      endcase

      shown        = (mode_in == MODE_COUNTDOWN) ? remaining_in : delay_in;
      rsp_tdata_in = {2'b00,
                      mode_in == MODE_INTRUDER,
                      mode_in == MODE_ARMED,
                      led_in[2], led_in[1], led_in[0],
                      shown,
                      mode_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_DISARMED;
         delay_ff        <= MIN_DELAY_RST;
         remaining_ff    <= '0;
         from_armed_ff   <= 1'b0;
         beam_latched_ff <= 1'b0;
         step_pending_ff <= 1'b0;
         step_down_ff    <= 1'b0;
         led_ff          <= LED_OFF;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            mode_ff         <= mode_in;
            delay_ff        <= delay_in;
            remaining_ff    <= remaining_in;
            from_armed_ff   <= from_armed_in;
            beam_latched_ff <= beam_latched_in;
            step_pending_ff <= step_pending_in;
            step_down_ff    <= step_down_in;
            led_ff          <= led_in;
            rsp_tvalid_ff   <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tvalid = rsp_tvalid_ff;

   // Never overwrite a status beat the receiver has not taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |-> !accept)
      else $error("poll accepted while status beat stalled");

   // Intruder stays latched while the switch is held on
   a_intruder_sticky: assert property (@(posedge clock) disable iff (reset)
      (accept && mode_ff == MODE_INTRUDER && arm) |=> mode_ff == MODE_INTRUDER)
      else $error("intruder left with switch on");

   // A poll with the switch off always reports disarmed
   a_switch_off: assert property (@(posedge clock) disable iff (reset)
      (accept && !arm) |=> (mode_ff == MODE_DISARMED && rsp_tdata_ff[1:0] == MODE_DISARMED))
      else $error("switch off did not disarm");

endmodule
`default_nettype wire
